// ===== rtl/alm_pkg.sv =====
// package for the audio level meter: types, constants, helpers
package alm_pkg;

	localparam int unsigned MaxChunkSamples = 4096;
	localparam int unsigned CntW = $clog2(MaxChunkSamples + 1);
	localparam int unsigned LvlW = 28;
	localparam int unsigned SumW = 52;
	localparam int unsigned TotW = 40;
	localparam int unsigned FstW = 32;
	localparam int unsigned DefaultUpdateHz = 30;
	localparam int unsigned NominalRate = 48000;
	localparam logic [19:0] TickReset = 20'(NominalRate / DefaultUpdateHz);

	localparam logic [LvlW-1:0] LvlMax = {LvlW{1'b1}};
	localparam logic [SumW-1:0] SumMax = {SumW{1'b1}};
	localparam logic [TotW-1:0] TotMax = {TotW{1'b1}};
	localparam logic [FstW-1:0] FstMax = {FstW{1'b1}};

	// register indexes
	localparam logic [2:0] RegFormat = 3'd0;
	localparam logic [2:0] RegChannels = 3'd1;
	localparam logic [2:0] RegGain = 3'd2;
	localparam logic [2:0] RegClip = 3'd3;
	localparam logic [2:0] RegSilence = 3'd4;
	localparam logic [2:0] RegTick = 3'd5;
	localparam logic [2:0] RegMaxDur = 3'd6;

	// sample formats
	localparam logic [1:0] FmtS16 = 2'd0;
	localparam logic [1:0] FmtS24 = 2'd1;
	localparam logic [1:0] FmtS32 = 2'd2;
	localparam logic [1:0] FmtF32 = 2'd3;

	// opcodes
	localparam logic OpSample = 1'b0;
	localparam logic OpClear = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL,
		ST_SQ,
		ST_ACC,
		ST_DIV,
		ST_SQRT,
		ST_OUT
	} state_t;

	// shared unit operations
	typedef enum logic [1:0] {
		OP_GAIN,
		OP_SQUARE,
		OP_DIVSTEP,
		OP_SQRTSTEP
	} unit_op_t;

	typedef struct packed {
		logic [1:0] sample_format;
		logic [3:0] channel_count;
		logic [15:0] input_gain;
		logic [LvlW-1:0] clip_threshold;
		logic [LvlW-1:0] silence_threshold;
		logic [19:0] frames_per_level_tick;
		logic [31:0] max_duration_frames;
	} cfg_t;

endpackage

// ===== rtl/audio_level_meter.sv =====
// audio level meter top level: sequencer, state and shared unit
//
//  channel | group                | content
//  in      | s_tvalid/tready      | tdata sample_word, tuser opcode, tlast last_in_chunk
//  out     | m_tvalid/tready      | tdata peak, rms; tuser flags
//  cfg     | cfg_we/index/data    | seven registers, no read-back
//
// a sample passes the gain multiply, square and accumulate steps through one
// shared multiply/subtract unit; a chunk end adds 52 divide steps and 32
// square-root steps on that unit, then waits for a free output register.
// reset clears the sequencer, peak, sum, counters and output valid.
// input ready is low while an item is in work or a result is held.
module audio_level_meter import alm_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [2:0] cfg_index,
	input logic [31:0] cfg_data,
	input logic s_tvalid,
	output logic s_tready,
	input logic [31:0] s_tdata, // sample_word
	input logic s_tuser, // opcode
	input logic s_tlast, // last_in_chunk
	output logic m_tvalid,
	input logic m_tready,
	output logic [55:0] m_tdata, // peak_level[27:0], rms_level[55:28]
	output logic [3:0] m_tuser // level_tick, clipping, silence, max_duration_reached
);

	cfg_t cfg;
	state_t state_q, state_d;
	unit_op_t op;

	logic [31:0] word_q;
	logic last_q;
	logic [23:0] mag;
	logic [LvlW-1:0] level_q, peak_q;
	logic [SumW-1:0] sum_q;
	logic [CntW-1:0] cnt_q;
	logic [2:0] pos_q;
	logic [TotW-1:0] tot_q;
	logic [FstW-1:0] fst_q;
	logic [63:0] rem_q, root_q, bit_q, quo_q;
	logic [5:0] step_q;
	logic [31:0] mul_a, mul_b;
	logic [63:0] mul_out, rem_in, rem_out, root_out, aux_in;
	logic take;
	logic [LvlW-1:0] opeak_q, orms_q;
	logic [3:0] oflags_q;
	logic [3:0] chans;
	logic [36:0] gl;
	logic [SumW:0] sum_add;

	alm_cfg u_cfg (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .cfg(cfg)
	);

	alm_scale u_scale (.fmt(cfg.sample_format), .w(word_q), .mag(mag));

	alm_unit u_unit (
		.op(op), .mul_a(mul_a), .mul_b(mul_b), .rem_in(rem_in), .aux_in(aux_in),
		.root_in(root_q), .bit_in(bit_q), .mul_out(mul_out), .rem_out(rem_out),
		.root_out(root_out), .take(take)
	);

	// unit operand selection
	always_comb begin
		op = OP_GAIN;
		mul_a = 32'(mag);
		mul_b = 32'(cfg.input_gain);
		rem_in = rem_q;
		aux_in = 64'(cnt_q);
		case (state_q)
			ST_SQ: begin
				op = OP_SQUARE;
				mul_a = 32'(level_q);
				mul_b = 32'(level_q);
			end
			ST_DIV: begin
				op = OP_DIVSTEP;
				rem_in = {rem_q[62:0], sum_q[SumW-1]};
			end
			ST_SQRT: op = OP_SQRTSTEP;
			default: ;
		endcase
	end

	assign gl = mul_out[47:11];
	assign sum_add = {1'b0, sum_q} + {1'b0, rem_q[SumW-1:0]};
	assign chans = (cfg.channel_count == 4'd0) ? 4'd1 :
		(cfg.channel_count > 4'd8) ? 4'd8 : cfg.channel_count;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (s_tvalid && s_tready && s_tuser == OpSample) state_d = ST_MUL;
			ST_MUL: state_d = ST_SQ;
			ST_SQ: state_d = ST_ACC;
			ST_ACC: state_d = !last_q ? ST_IDLE : ST_DIV;
			ST_DIV: if (step_q == 6'(SumW - 1)) state_d = ST_SQRT;
			ST_SQRT: if (step_q == 6'd31) state_d = ST_OUT;
			ST_OUT: if (!m_tvalid) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		s_tready = (state_q == ST_IDLE) && !m_tvalid;
	end

	logic mv_q;
	assign m_tvalid = mv_q;
	assign m_tdata = {orms_q, opeak_q};
	assign m_tuser = oflags_q;

	// datapath and control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			peak_q <= '0;
			sum_q <= '0;
			cnt_q <= '0;
			pos_q <= '0;
			tot_q <= '0;
			fst_q <= '0;
			mv_q <= 1'b0;
			step_q <= '0;
		end else begin
			state_q <= state_d;
			if (mv_q && m_tready) mv_q <= 1'b0;
			case (state_q)
				ST_IDLE: if (s_tvalid && s_tready) begin
					word_q <= s_tdata;
					last_q <= s_tlast;
					if (s_tuser == OpClear) tot_q <= '0;
				end
				ST_MUL: begin
					level_q <= (gl > 37'(LvlMax)) ? LvlMax : gl[LvlW-1:0];
				end
				ST_SQ: begin
					rem_q <= mul_out >> 16;
					if (level_q > peak_q) peak_q <= level_q;
				end
				ST_ACC: begin
					if (cnt_q < CntW'(MaxChunkSamples)) begin
						cnt_q <= cnt_q + 1'b1;
						sum_q <= sum_add[SumW] ? SumMax : sum_add[SumW-1:0];
					end
					if (4'({1'b0, pos_q}) + 4'd1 >= chans) begin
						pos_q <= '0;
						if (tot_q != TotMax) tot_q <= tot_q + 1'b1;
						if (fst_q != FstMax) fst_q <= fst_q + 1'b1;
					end else begin
						pos_q <= pos_q + 1'b1;
					end
					rem_q <= '0;
					quo_q <= '0;
					step_q <= '0;
				end
				ST_DIV: begin
					quo_q <= {quo_q[62:0], take};
					sum_q <= {sum_q[SumW-2:0], 1'b0};
					if (step_q == 6'(SumW - 1)) begin
						// mean shifted up 16 as the square-root operand
						rem_q <= {quo_q[46:0], take, 16'b0};
						root_q <= '0;
						bit_q <= 64'h4000_0000_0000_0000;
						step_q <= '0;
					end else begin
						rem_q <= rem_out;
						step_q <= step_q + 1'b1;
					end
				end
				ST_SQRT: begin
					rem_q <= rem_out;
					root_q <= root_out;
					bit_q <= bit_q >> 2;
					step_q <= step_q + 1'b1;
				end
				ST_OUT: if (!mv_q) begin
					logic [LvlW-1:0] r;
					logic tk;
					r = (state_q == ST_OUT && cnt_q == '0) ? '0 :
						(root_q > 64'(LvlMax)) ? LvlMax : root_q[LvlW-1:0];
					tk = fst_q >= FstW'(cfg.frames_per_level_tick);
					if (tk) fst_q <= '0;
					opeak_q <= peak_q;
					orms_q <= r;
					oflags_q[0] <= tk;
					oflags_q[1] <= tk && (peak_q >= cfg.clip_threshold);
					oflags_q[2] <= tk && (r < cfg.silence_threshold);
					oflags_q[3] <= (cfg.max_duration_frames != '0) &&
						(tot_q >= TotW'(cfg.max_duration_frames));
					mv_q <= 1'b1;
					peak_q <= '0;
					sum_q <= '0;
					cnt_q <= '0;
					root_q <= '0;
				end
				default: ;
			endcase
		end
	end

endmodule

// ===== rtl/alm_cfg.sv =====
// configuration register file
module alm_cfg import alm_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [2:0] cfg_index,
	input logic [31:0] cfg_data,
	output cfg_t cfg
);

	cfg_t cfg_q;

	// register writes, masked to width
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sample_format <= FmtS16;
			cfg_q.channel_count <= 4'd2;
			cfg_q.input_gain <= 16'd4096;
			cfg_q.clip_threshold <= 28'd16777216;
			cfg_q.silence_threshold <= '0;
			cfg_q.frames_per_level_tick <= TickReset;
			cfg_q.max_duration_frames <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				RegFormat: cfg_q.sample_format <= cfg_data[1:0];
				RegChannels: cfg_q.channel_count <= cfg_data[3:0];
				RegGain: cfg_q.input_gain <= cfg_data[15:0];
				RegClip: cfg_q.clip_threshold <= cfg_data[LvlW-1:0];
				RegSilence: cfg_q.silence_threshold <= cfg_data[LvlW-1:0];
				RegTick: cfg_q.frames_per_level_tick <= cfg_data[19:0];
				RegMaxDur: cfg_q.max_duration_frames <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== rtl/alm_unit.sv =====
// shared arithmetic unit: gain multiply, square, restoring divide step, sqrt step
module alm_unit import alm_pkg::*; (
	input unit_op_t op,
	input logic [31:0] mul_a,
	input logic [31:0] mul_b,
	input logic [63:0] rem_in,
	input logic [63:0] aux_in,
	input logic [63:0] root_in,
	input logic [63:0] bit_in,
	output logic [63:0] mul_out,
	output logic [63:0] rem_out,
	output logic [63:0] root_out,
	output logic take
);

	logic [64:0] trial;

	// one multiply, or one subtract and compare
	always_comb begin
		mul_out = '0;
		rem_out = rem_in;
		root_out = root_in;
		trial = '0;
		take = 1'b0;
		case (op)
			OP_GAIN, OP_SQUARE: begin
				mul_out = 64'(mul_a) * 64'(mul_b);
			end
			OP_DIVSTEP: begin
				// rem_in already shifted with next dividend bit; aux_in divisor
				trial = {1'b0, rem_in} - {1'b0, aux_in};
				take = !trial[64];
				if (take) rem_out = trial[63:0];
			end
			OP_SQRTSTEP: begin
				trial = {1'b0, rem_in} - ({1'b0, root_in} + {1'b0, bit_in});
				take = !trial[64];
				if (take) begin
					rem_out = trial[63:0];
					root_out = (root_in >> 1) + bit_in;
				end else begin
					root_out = root_in >> 1;
				end
			end
			default: ;
		endcase
	end

endmodule

// ===== rtl/alm_scale.sv =====
// raw sample to Q1.23 magnitude
module alm_scale import alm_pkg::*; (
	input logic [1:0] fmt,
	input logic [31:0] w,
	output logic [23:0] mag
);

	logic [32:0] neg;
	logic [7:0] e;
	logic [23:0] cap;
	logic [7:0] sh;
	logic [23:0] shifted;

	// per-format decode, float with one barrel shift
	always_comb begin
		neg = 33'h1_0000_0000 - {1'b0, w};
		e = w[30:23];
		cap = w[31] ? 24'h800000 : 24'h7FFFFF;
		sh = 8'd127 - e;
		shifted = {1'b1, w[22:0]} >> sh[4:0];
		mag = '0;
		case (fmt)
			FmtS16: mag = w[15] ? 24'({17'h10000 - {1'b0, w[15:0]}, 8'h0}) : {w[15:0], 8'h0};
			FmtS24: mag = w[23] ? 24'(25'h1000000 - {1'b0, w[23:0]}) : w[23:0];
			FmtS32: mag = w[31] ? 24'((neg + 33'd255) >> 8) : w[31:8];
			FmtF32: begin
				if (e == 8'hFF) mag = (w[22:0] != '0) ? 24'd0 : cap;
				else if (e == 8'h00) mag = '0;
				else if (e >= 8'd127) mag = cap;
				else if (sh >= 8'd32) mag = '0;
				else if (sh >= 8'd24) mag = '0;
				else mag = (shifted > cap) ? cap : shifted;
			end
			default: mag = '0;
		endcase
	end

endmodule
